// ----- src/hnms_pkg.sv -----
// Shared constants, record types, state and handshake structs for the keypoint NMS block.
package hnms_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 512;
    localparam int MAX_CANDIDATES = 4096;
    localparam int PROB_BITS      = 16;
    localparam int MIN_SIZE       = 16;
    localparam int WIN_LOW        = 4;
    localparam int WIN_HIGH       = 10;

    localparam int X_W   = 10;
    localparam int Y_W   = 9;
    localparam int IDX_W = 12;
    localparam int CNT_W = 13;
    localparam int CW_W  = 11;
    localparam int CH_W  = 10;
    localparam int RAD_W = 3;
    localparam int MRG_W = 6;

    typedef struct packed {
        logic [PROB_BITS-1:0] r;
        logic [Y_W-1:0]       y;
        logic [X_W-1:0]       x;
    } point_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        point_t           pt;
    } sort_rec_t;

    typedef enum logic [2:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_WIDTH     = 3'd1,
        CFG_HEIGHT    = 3'd2,
        CFG_NMS_EN    = 3'd3,
        CFG_RADIUS    = 3'd4,
        CFG_MARGIN    = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RESULT,
        ST_FETCH,
        ST_SORT_INIT,
        ST_SORT_RD,
        ST_SORT_WR,
        ST_NMS_RD,
        ST_NMS_GET,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    typedef struct packed {
        logic accept;
        logic in_results;
        logic sort_init;
        logic sort_next_block;
        logic sort_write;
        logic nms_read;
        logic nms_get;
        logic scan_keep;
        logic scan_drop;
        logic scan_next;
        logic emit_write;
        logic fetch_out;
    } cmd_t;

    typedef struct packed {
        logic take_load;
        logic take_fetch;
        logic frame_last;
        logic has_result;
        logic sort_none;
        logic blk_done;
        logic pass_end;
        logic last_pass;
        logic s_done;
        logic nms_on;
        logic scan_end;
        logic scan_lower;
        logic scan_near;
        logic i_done;
    } status_t;

endpackage

// ----- src/hnms_ram.sv -----
// Generic RAM with one write port and two registered read ports.
module hnms_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd0_addr,
    output logic [DATA_W-1:0] rd0_data,
    input  logic [ADDR_W-1:0] rd1_addr,
    output logic [DATA_W-1:0] rd1_data
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] rd0_data_reg;
    logic [DATA_W-1:0] rd1_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd0_data_reg <= mem[rd0_addr];
        rd1_data_reg <= mem[rd1_addr];
    end

    assign rd0_data = rd0_data_reg;
    assign rd1_data = rd1_data_reg;

endmodule

// ----- src/hnms_datapath.sv -----
// Datapath: configuration, pixel counters, candidate stores, merge sort, suppression and output word.
module hnms_datapath
    import hnms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_action,
    input  logic [PROB_BITS-1:0] in_prob,
    output logic                 out_valid,
    input  logic                 out_ready,
    output point_t               out_pt,
    output logic                 out_vres,
    output logic                 out_final,
    output logic                 out_ovf,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    function automatic logic [CNT_W-1:0] clip(input logic [CNT_W:0] v, input logic [CNT_W-1:0] n);
        return (v >= {1'b0, n}) ? n : v[CNT_W-1:0];
    endfunction

    logic [PROB_BITS-1:0] thr_reg;
    logic [CW_W-1:0]      width_reg;
    logic [CH_W-1:0]      height_reg;
    logic                 nms_en_reg;
    logic [RAD_W-1:0]     radius_reg;
    logic [MRG_W-1:0]     margin_reg;

    logic [X_W-1:0]   col_reg, col_next;
    logic [Y_W-1:0]   row_reg, row_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] ecnt_reg, ecnt_next;
    logic [CNT_W-1:0] s_reg, s_next;
    logic [CNT_W-1:0] kcnt_reg, kcnt_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] w_reg, w_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] a_reg, a_next;
    logic [CNT_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             src_reg, src_next;
    logic             out_valid_reg, out_valid_next;
    sort_rec_t        c_reg;
    point_t           out_pt_reg;
    logic             out_vres_reg, out_final_reg, out_ovf_reg;

    logic [CW_W-1:0]  eff_w;
    logic [CH_W-1:0]  eff_h;
    logic             out_free, take_load, take_fetch, is_cand, col_wrap, frame_last;
    logic [CW_W-1:0]  col_inc;
    logic [CH_W-1:0]  row_inc;
    logic [CNT_W-1:0] base_cnt;
    logic             base_ovf, store_ok;
    logic             out_load, out_none;

    sort_rec_t        sa_rd0, sa_rd1, sb_rd0, sb_rd1, da, db, new_rec, sort_wdata;
    logic             sa_we, sb_we, take_a;
    logic [IDX_W-1:0] sort_waddr, sort_raddr0;
    logic [CNT_W:0]   lo2, blk_sum, blk_sum2;
    logic [CNT_W-1:0] blk_lo, blk_w, nxt_lo, nxt_w;

    point_t           cand_rd, keep_rd, emit_rd, emit_wdata;
    logic             cand_we, keep_we, kbit_we, kbit_wdata, kbit_rd, emit_we;
    logic [IDX_W-1:0] kbit_waddr;
    logic [X_W-1:0]   xd;
    logic [Y_W-1:0]   yd;
    logic             margin_ok;

    always_comb
    begin
        if (width_reg < CW_W'(MIN_SIZE))
            eff_w = CW_W'(MIN_SIZE);
        else if (width_reg > CW_W'(MAX_WIDTH))
            eff_w = CW_W'(MAX_WIDTH);
        else
            eff_w = width_reg;
        if (height_reg < CH_W'(MIN_SIZE))
            eff_h = CH_W'(MIN_SIZE);
        else if (height_reg > CH_W'(MAX_HEIGHT))
            eff_h = CH_W'(MAX_HEIGHT);
        else
            eff_h = height_reg;
    end

    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = cmd.accept && out_free;
    assign cfg_ready  = cmd.accept;
    assign take_load  = in_valid && in_ready && !in_action;
    assign take_fetch = in_valid && in_ready && in_action;

    assign col_inc    = {1'b0, col_reg} + CW_W'(1);
    assign row_inc    = {1'b0, row_reg} + CH_W'(1);
    assign col_wrap   = col_inc >= eff_w;
    assign frame_last = col_wrap && (row_inc >= eff_h);
    assign is_cand    = (row_reg >= Y_W'(WIN_LOW))
                     && (({1'b0, row_reg} + CH_W'(WIN_HIGH)) < eff_h)
                     && (col_reg >= X_W'(WIN_LOW))
                     && (({1'b0, col_reg} + CW_W'(WIN_HIGH)) < eff_w)
                     && (in_prob > thr_reg);
    assign base_cnt   = cmd.in_results ? '0 : cnt_reg;
    assign base_ovf   = cmd.in_results ? 1'b0 : ovf_reg;
    assign store_ok   = base_cnt < CNT_W'(MAX_CANDIDATES);
    assign cand_we    = take_load && is_cand && store_ok;
    assign new_rec    = '{idx: base_cnt[IDX_W-1:0], pt: '{r: in_prob, y: row_reg, x: col_reg}};

    assign da     = src_reg ? sb_rd0 : sa_rd0;
    assign db     = src_reg ? sb_rd1 : sa_rd1;
    assign take_a = (b_reg >= hi_reg) || ((a_reg < mid_reg) && (da.pt.r >= db.pt.r));
    assign lo2    = {1'b0, lo_reg} + {w_reg, 1'b0};
    assign nxt_w  = (lo2 >= {1'b0, cnt_reg}) ? {w_reg[CNT_W-2:0], 1'b0} : w_reg;
    assign nxt_lo = (lo2 >= {1'b0, cnt_reg}) ? '0 : lo2[CNT_W-1:0];
    assign blk_lo = cmd.sort_init ? '0 : nxt_lo;
    assign blk_w  = cmd.sort_init ? CNT_W'(1) : nxt_w;
    assign blk_sum  = {1'b0, blk_lo} + {1'b0, blk_w};
    assign blk_sum2 = {1'b0, blk_lo} + {blk_w, 1'b0};

    assign sort_raddr0 = cmd.nms_read ? s_reg[IDX_W-1:0] : a_reg[IDX_W-1:0];
    assign sort_waddr  = take_load ? base_cnt[IDX_W-1:0] : k_reg[IDX_W-1:0];
    assign sort_wdata  = take_load ? new_rec : (take_a ? da : db);
    assign sa_we       = cand_we || (cmd.sort_write && src_reg);
    assign sb_we       = cmd.sort_write && !src_reg;

    assign xd = (keep_rd.x >= c_reg.pt.x) ? keep_rd.x - c_reg.pt.x : c_reg.pt.x - keep_rd.x;
    assign yd = (keep_rd.y >= c_reg.pt.y) ? keep_rd.y - c_reg.pt.y : c_reg.pt.y - keep_rd.y;

    assign keep_we    = cmd.scan_keep;
    assign kbit_we    = cmd.scan_keep || cmd.scan_drop;
    assign kbit_wdata = cmd.scan_keep;
    assign kbit_waddr = c_reg.idx;

    assign margin_ok = !((cand_rd.x < X_W'(margin_reg))
                      || (({1'b0, cand_rd.x} + CW_W'(margin_reg)) >= eff_w)
                      || (cand_rd.y < Y_W'(margin_reg))
                      || (({2'b0, cand_rd.y} + CW_W'(margin_reg)) >= {1'b0, eff_h}));
    assign emit_we    = (cmd.nms_get && !nms_en_reg) || (cmd.emit_write && kbit_rd && margin_ok);
    assign emit_wdata = cmd.nms_get ? da.pt : cand_rd;

    assign out_none = take_fetch && !(cmd.in_results && (ptr_reg < ecnt_reg));
    assign out_load = out_none || cmd.fetch_out;

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        ptr_next       = ptr_reg;
        ecnt_next      = ecnt_reg;
        s_next         = s_reg;
        kcnt_next      = kcnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        w_next         = w_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        src_next       = src_reg;
        out_valid_next = out_valid_reg;

        if (take_load)
        begin
            cnt_next = base_cnt;
            ovf_next = base_ovf;
            if (cmd.in_results)
            begin
                ptr_next  = '0;
                ecnt_next = '0;
            end
            if (is_cand)
            begin
                if (store_ok)
                    cnt_next = base_cnt + CNT_W'(1);
                else
                    ovf_next = 1'b1;
            end
            if (col_wrap)
            begin
                col_next = '0;
                row_next = frame_last ? '0 : row_inc[Y_W-1:0];
            end
            else
            begin
                col_next = col_inc[X_W-1:0];
            end
        end

        if (cmd.sort_init || cmd.sort_next_block)
        begin
            w_next   = blk_w;
            lo_next  = blk_lo;
            mid_next = clip(blk_sum, cnt_reg);
            hi_next  = clip(blk_sum2, cnt_reg);
            a_next   = blk_lo;
            b_next   = clip(blk_sum, cnt_reg);
            k_next   = blk_lo;
        end
        if (cmd.sort_init)
        begin
            src_next  = 1'b0;
            s_next    = '0;
            kcnt_next = '0;
            i_next    = '0;
            ecnt_next = '0;
            ptr_next  = '0;
        end
        if (cmd.sort_next_block && (lo2 >= {1'b0, cnt_reg}))
            src_next = !src_reg;
        if (cmd.sort_write)
        begin
            k_next = k_reg + CNT_W'(1);
            if (take_a)
                a_next = a_reg + CNT_W'(1);
            else
                b_next = b_reg + CNT_W'(1);
        end

        if (cmd.nms_get)
        begin
            j_next = '0;
            if (!nms_en_reg)
                s_next = s_reg + CNT_W'(1);
        end
        if (cmd.scan_keep || cmd.scan_drop)
            s_next = s_reg + CNT_W'(1);
        if (cmd.scan_keep)
            kcnt_next = kcnt_reg + CNT_W'(1);
        if (cmd.scan_next)
            j_next = j_reg + CNT_W'(1);
        if (cmd.emit_write)
            i_next = i_reg + CNT_W'(1);
        if (emit_we)
            ecnt_next = ecnt_reg + CNT_W'(1);
        if (cmd.fetch_out)
            ptr_next = ptr_reg + CNT_W'(1);

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= 16'd983;
            width_reg     <= 11'd640;
            height_reg    <= 10'd480;
            nms_en_reg    <= 1'b1;
            radius_reg    <= 3'd4;
            margin_reg    <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            ptr_reg       <= '0;
            ecnt_reg      <= '0;
            s_reg         <= '0;
            kcnt_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            w_reg         <= '0;
            lo_reg        <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            k_reg         <= '0;
            src_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_THRESHOLD: thr_reg    <= cfg_data;
                    CFG_WIDTH:     width_reg  <= cfg_data[CW_W-1:0];
                    CFG_HEIGHT:    height_reg <= cfg_data[CH_W-1:0];
                    CFG_NMS_EN:    nms_en_reg <= cfg_data[0];
                    CFG_RADIUS:    radius_reg <= cfg_data[RAD_W-1:0];
                    CFG_MARGIN:    margin_reg <= cfg_data[MRG_W-1:0];
                    default:       ;
                endcase
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            ptr_reg       <= ptr_next;
            ecnt_reg      <= ecnt_next;
            s_reg         <= s_next;
            kcnt_reg      <= kcnt_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            w_reg         <= w_next;
            lo_reg        <= lo_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            k_reg         <= k_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.nms_get)
            c_reg <= da;
        if (out_load)
        begin
            out_ovf_reg <= ovf_next;
            if (cmd.fetch_out)
            begin
                out_pt_reg    <= emit_rd;
                out_vres_reg  <= 1'b1;
                out_final_reg <= (ptr_reg + CNT_W'(1)) == ecnt_reg;
            end
            else
            begin
                out_pt_reg    <= '0;
                out_vres_reg  <= 1'b0;
                out_final_reg <= 1'b0;
            end
        end
    end

    hnms_ram #(.DATA_W($bits(point_t)), .ADDR_W(IDX_W)) u_cand_ram (
        .clk(clk), .we(cand_we), .wr_addr(base_cnt[IDX_W-1:0]), .wr_data(new_rec.pt),
        .rd0_addr(i_reg[IDX_W-1:0]), .rd0_data(cand_rd),
        .rd1_addr(i_reg[IDX_W-1:0]), .rd1_data()
    );

    hnms_ram #(.DATA_W($bits(sort_rec_t)), .ADDR_W(IDX_W)) u_sort_a_ram (
        .clk(clk), .we(sa_we), .wr_addr(sort_waddr), .wr_data(sort_wdata),
        .rd0_addr(sort_raddr0), .rd0_data(sa_rd0),
        .rd1_addr(b_reg[IDX_W-1:0]), .rd1_data(sa_rd1)
    );

    hnms_ram #(.DATA_W($bits(sort_rec_t)), .ADDR_W(IDX_W)) u_sort_b_ram (
        .clk(clk), .we(sb_we), .wr_addr(sort_waddr), .wr_data(sort_wdata),
        .rd0_addr(sort_raddr0), .rd0_data(sb_rd0),
        .rd1_addr(b_reg[IDX_W-1:0]), .rd1_data(sb_rd1)
    );

    hnms_ram #(.DATA_W($bits(point_t)), .ADDR_W(IDX_W)) u_keep_ram (
        .clk(clk), .we(keep_we), .wr_addr(kcnt_reg[IDX_W-1:0]), .wr_data(c_reg.pt),
        .rd0_addr(j_reg[IDX_W-1:0]), .rd0_data(keep_rd),
        .rd1_addr(j_reg[IDX_W-1:0]), .rd1_data()
    );

    hnms_ram #(.DATA_W(1), .ADDR_W(IDX_W)) u_keep_bit_ram (
        .clk(clk), .we(kbit_we), .wr_addr(kbit_waddr), .wr_data(kbit_wdata),
        .rd0_addr(i_reg[IDX_W-1:0]), .rd0_data(kbit_rd),
        .rd1_addr(i_reg[IDX_W-1:0]), .rd1_data()
    );

    hnms_ram #(.DATA_W($bits(point_t)), .ADDR_W(IDX_W)) u_emit_ram (
        .clk(clk), .we(emit_we), .wr_addr(ecnt_reg[IDX_W-1:0]), .wr_data(emit_wdata),
        .rd0_addr(ptr_reg[IDX_W-1:0]), .rd0_data(emit_rd),
        .rd1_addr(ptr_reg[IDX_W-1:0]), .rd1_data()
    );

    assign status.take_load  = take_load;
    assign status.take_fetch = take_fetch;
    assign status.frame_last = frame_last;
    assign status.has_result = ptr_reg < ecnt_reg;
    assign status.sort_none  = cnt_reg <= CNT_W'(1);
    assign status.blk_done   = (a_reg >= mid_reg) && (b_reg >= hi_reg);
    assign status.pass_end   = lo2 >= {1'b0, cnt_reg};
    assign status.last_pass  = {w_reg, 1'b0} >= {1'b0, cnt_reg};
    assign status.s_done     = s_reg >= cnt_reg;
    assign status.nms_on     = nms_en_reg;
    assign status.scan_end   = j_reg >= kcnt_reg;
    assign status.scan_lower = keep_rd.r <= c_reg.pt.r;
    assign status.scan_near  = (xd <= X_W'(radius_reg)) && (yd <= Y_W'(radius_reg));
    assign status.i_done     = i_reg >= cnt_reg;

    assign out_valid = out_valid_reg;
    assign out_pt    = out_pt_reg;
    assign out_vres  = out_vres_reg;
    assign out_final = out_final_reg;
    assign out_ovf   = out_ovf_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_CANDIDATES))
        else $error("Candidate count exceeds the store capacity.");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_valid_reg) |-> out_ready)
        else $error("Output word overwritten before it was taken.");

    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_keep || cmd.scan_drop) |-> (kcnt_reg <= s_reg))
        else $error("More kept points than processed candidates.");

    a_fetch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch_out |-> (ptr_reg < ecnt_reg))
        else $error("Fetch read past the end of the result list.");

endmodule

// ----- src/hnms_ctrl.sv -----
// Controller state machine that sequences loading, sorting, suppression and result fetch.
module hnms_ctrl
    import hnms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.accept = 1'b1;
                if (status.take_load && status.frame_last)
                    state_next = ST_SORT_INIT;
            end
            ST_RESULT:
            begin
                cmd.accept     = 1'b1;
                cmd.in_results = 1'b1;
                if (status.take_load)
                    state_next = status.frame_last ? ST_SORT_INIT : ST_LOAD;
                else if (status.take_fetch && status.has_result)
                    state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.fetch_out = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_SORT_INIT:
            begin
                cmd.sort_init = 1'b1;
                state_next    = status.sort_none ? ST_NMS_RD : ST_SORT_RD;
            end
            ST_SORT_RD:
            begin
                if (status.blk_done)
                begin
                    cmd.sort_next_block = 1'b1;
                    if (status.pass_end && status.last_pass)
                        state_next = ST_NMS_RD;
                end
                else
                begin
                    state_next = ST_SORT_WR;
                end
            end
            ST_SORT_WR:
            begin
                cmd.sort_write = 1'b1;
                state_next     = ST_SORT_RD;
            end
            ST_NMS_RD:
            begin
                cmd.nms_read = 1'b1;
                if (status.s_done)
                    state_next = status.nms_on ? ST_EMIT_RD : ST_RESULT;
                else
                    state_next = ST_NMS_GET;
            end
            ST_NMS_GET:
            begin
                cmd.nms_get = 1'b1;
                state_next  = status.nms_on ? ST_SCAN_RD : ST_NMS_RD;
            end
            ST_SCAN_RD:
            begin
                if (status.scan_end)
                begin
                    cmd.scan_keep = 1'b1;
                    state_next    = ST_NMS_RD;
                end
                else
                begin
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP:
            begin
                if (status.scan_lower)
                begin
                    cmd.scan_keep = 1'b1;
                    state_next    = ST_NMS_RD;
                end
                else if (status.scan_near)
                begin
                    cmd.scan_drop = 1'b1;
                    state_next    = ST_NMS_RD;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = status.i_done ? ST_RESULT : ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                cmd.emit_write = 1'b1;
                state_next     = ST_EMIT_RD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ----- src/heatmap_threshold_sort_grid_nms_unit.sv -----
// Top level of the keypoint heatmap threshold, sort and grid suppression unit.
//
// The slave stream carries one word per pixel or fetch: tuser[0] is the action
// (0 loads a heatmap pixel, 1 fetches a keypoint) and tdata holds the probability.
// Pixels arrive in raster order and are taken one per cycle while loading, unless
// a held result stalls them. After the last pixel the unit sorts its candidates
// with a bottom-up merge sort; with suppression enabled it then scans each sorted
// candidate against the kept list and sweeps the candidates in raster order.
// No word is accepted during these phases. A fetch answers with one master word,
// read from the result list through the fetch state, or in the next cycle when
// no keypoint remains. tlast marks the last keypoint of the frame.
// The output register lets a new word be accepted in the cycle the pending
// result is taken; while the receiver stalls with a result held, tready is low.
// Reset restores the register defaults and starts an empty frame; the stores
// need no clearing pass. Configuration is written only in the load and result states.
module heatmap_threshold_sort_grid_nms_unit
    import hnms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // prob
    input  logic [0:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // key_x, key_y, response, zero fill
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser,   // valid_res, overflowed
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cmd_t    cmd;
    status_t status;
    point_t  out_pt;
    logic    out_vres, out_ovf;

    hnms_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .status(status),
        .cmd(cmd)
    );

    hnms_datapath u_datapath (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .status(status),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .in_action(s_axis_tuser[0]),
        .in_prob(s_axis_tdata),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_pt(out_pt),
        .out_vres(out_vres),
        .out_final(m_axis_tlast),
        .out_ovf(out_ovf),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    assign m_axis_tdata = {5'b0, out_pt.r, out_pt.y, out_pt.x};
    assign m_axis_tuser = {out_ovf, out_vres};

endmodule
